// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the positional array list files: the request
// and result beats, the per-cell control word and the request codes.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;
  // Wide enough to compare any cell index against a slot number.
  localparam int unsigned IDX_W   = 9;

  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] value_out;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // Broadcast to every cell for one accepted request.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [POS_W-1:0]         slot;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Loads the new value, takes its left neighbor's word on an
// insert, or its right neighbor's word on a delete, and offers its word to
// the read tree when its index matches the addressed slot.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                             clk,
  input  pal_pkg::cell_ctrl_t              ctrl,
  input  logic signed [pal_pkg::DATA_W-1:0] left_data,
  input  logic signed [pal_pkg::DATA_W-1:0] right_data,
  output logic signed [pal_pkg::DATA_W-1:0] data,
  output logic signed [pal_pkg::DATA_W-1:0] rd_data
);

  localparam logic [pal_pkg::IDX_W-1:0] IDX = pal_pkg::IDX_W'(INDEX);

  logic signed [pal_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [pal_pkg::IDX_W-1:0]         slot;
  logic                              eq, gt;

  assign slot = pal_pkg::IDX_W'(ctrl.slot);
  assign eq   = (IDX == slot);
  assign gt   = (IDX > slot);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins && eq) begin
      data_nxt = ctrl.value;
    end else if (ctrl.ins && gt) begin
      data_nxt = left_data;
    end else if (ctrl.del && (eq || gt)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = eq ? data_r : '0;

endmodule

// ===== rtl/pal_outbuf.sv =====
// ----------------------------------------------------------------------------
// pal_outbuf
// Result register with one skid entry, so a new request can still be taken
// while the downstream side holds the current result.
// ----------------------------------------------------------------------------
module pal_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pal_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output pal_pkg::out_item_t out_data
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  pal_pkg::out_item_t main_r, main_nxt;
  pal_pkg::out_item_t skid_r, skid_nxt;
  logic               held;

  assign held = main_valid_r && out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (held) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end else if (skid_valid_r) begin
      main_valid_nxt = 1'b1;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end else begin
      main_valid_nxt = push;
      main_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== rtl/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed words with read, insert and delete at a one-based
// position, held in a row of cells that all shift together.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall   | opcode, position, value_in
//   out     | output    | out_valid/out_stall | ok, value_out, count
//
// One request is accepted per cycle while in_stall is low; its result is registered in the output buffer.
// Every cell moves in the same cycle, so the shift itself sets that rate,
// and the read value comes from an OR tree across all cells.
// Reset clears the length; the slots hold no defined data until written.
// in_stall rises once a result is held downstream and a second result has
// filled the skid entry; it drops right after the held beat leaves.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pal_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pal_pkg::out_item_t out_data
);

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  =
    ((FILL_W > pal_pkg::POS_W) ? FILL_W : pal_pkg::POS_W) + 1;

  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                accept;
  logic [CMP_W-1:0]    pos_c, fill_c, fill_ext;
  logic                hit, ins_ok, ok;
  pal_pkg::cell_ctrl_t ctrl;
  pal_pkg::out_item_t  result;

  logic signed [pal_pkg::DATA_W-1:0] cell_w  [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] left_w  [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] right_w [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] rd_w    [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] rd_val;

  assign accept = in_valid && !in_stall;
  assign pos_c  = CMP_W'(in_data.position);
  assign fill_c = CMP_W'(fill_r);
  assign hit    = (pos_c != '0) && (pos_c <= fill_c);
  assign ins_ok = (fill_c < CMP_W'(CAPACITY)) && (pos_c != '0) &&
                  (pos_c <= fill_c + CMP_W'(1));

  always_comb begin
    unique case (in_data.opcode)
      pal_pkg::OP_READ:   ok = hit;
      pal_pkg::OP_INSERT: ok = ins_ok;
      pal_pkg::OP_DELETE: ok = hit;
      default:            ok = 1'b0;
    endcase
  end

  assign ctrl.ins   = accept && ok && (in_data.opcode == pal_pkg::OP_INSERT);
  assign ctrl.del   = accept && ok && (in_data.opcode == pal_pkg::OP_DELETE);
  assign ctrl.slot  = in_data.position - pal_pkg::POS_W'(1);
  assign ctrl.value = in_data.value_in;

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.ins) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (ctrl.del) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_w[i] = ctrl.value;
      end else begin : g_mid_l
        assign left_w[i] = cell_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w[i] = cell_w[i];
      end else begin : g_mid_r
        assign right_w[i] = cell_w[i+1];
      end
      pal_cell #(
        .INDEX(i)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .left_data (left_w[i]),
        .right_data(right_w[i]),
        .data      (cell_w[i]),
        .rd_data   (rd_w[i])
      );
    end
  endgenerate

  // At most one cell matches the slot, so an OR gathers its word.
  always_comb begin
    rd_val = '0;
    for (int n = 0; n < CAPACITY; n++) begin
      rd_val = rd_val | rd_w[n];
    end
  end

  assign fill_ext         = CMP_W'(fill_nxt);
  assign result.ok        = ok;
  assign result.value_out = (ok && (in_data.opcode != pal_pkg::OP_INSERT)) ? rd_val : '0;
  assign result.count     = fill_ext[pal_pkg::COUNT_W-1:0];

  pal_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(result),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== rtl/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks for the positional array list: a held result beat stays
// put, the input side only stalls behind a pending result, and a rejected
// request carries a zero word.
// ----------------------------------------------------------------------------
module pal_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pal_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pal_pkg::out_item_t out_data
);

  // A stalled result beat keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The input side only stalls while a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Once the downstream side takes a beat, the input side cannot stay stalled.
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !in_stall)
    else $error("input still stalled after a result beat left");

  // A rejected request never carries a list word.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.value_out == '0)
    else $error("rejected request returned a nonzero word");

  // Every accepted request beat carries a known opcode.
  a_no_input_x: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_data.opcode) || !in_valid)
    else $error("accepted request with unknown opcode");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
